FILE: hdl/irpws_pkg.sv
// shared types and constants for the ir ring pulse width statistics unit
`default_nettype none

package irpws_pkg;

  // fixed field widths of the channels
  localparam int SAMPLE_PINS_W  = 15;
  localparam int SENSOR_INDEX_W = 4;
  localparam int PULSE_WIDTH_W  = 24;
  localparam int ACTIVE_COUNT_W = 4;
  localparam int WIDTH_TOTAL_W  = 28;
  localparam int MAX_WIDTH_W    = 24;
  localparam int MAX_SENSOR_W   = 4;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int WINDOW_W    = 16;
  localparam int STEP_W      = 8;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd1000;
  localparam logic [STEP_W-1:0]   STEP_RESET   = 8'd1;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WINDOW_SAMPLES = 2'd0,
    REG_STEP_SIZE      = 2'd1
  } cfg_reg_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

endpackage

`default_nettype wire

FILE: hdl/irpws_if.sv
// channel interfaces: configuration writes, pin samples and report rows
`default_nettype none

// configuration write channel
interface irpws_cfg_if;
  import irpws_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// pin sample channel
interface irpws_in_if;
  import irpws_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [SAMPLE_PINS_W-1:0] sample_pins;
  modport source (output valid, output sample_pins, input ready);
  modport sink   (input valid, input sample_pins, output ready);
endinterface

// report row channel
interface irpws_out_if;
  import irpws_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [SENSOR_INDEX_W-1:0] sensor_index;
  logic [PULSE_WIDTH_W-1:0]  pulse_width;
  logic [ACTIVE_COUNT_W-1:0] active_count;
  logic [WIDTH_TOTAL_W-1:0]  width_total;
  logic [MAX_WIDTH_W-1:0]    max_width;
  logic [MAX_SENSOR_W-1:0]   max_sensor;
  logic                      last_of_run;
  modport source (output valid, output sensor_index, output pulse_width, output active_count,
                  output width_total, output max_width, output max_sensor,
                  output last_of_run, input ready);
  modport sink   (input valid, input sensor_index, input pulse_width, input active_count,
                  input width_total, input max_width, input max_sensor,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: hdl/ir_ring_pulse_width_stats_unit.sv
// ir receiver ring pulse width statistics unit, top level
//
// Usage: every request on in_i carries one sample of the receiver lines, bit i
// low meaning sensor i is receiving. Widths live in a one-port-read,
// one-port-write counter memory and are updated by a sweep over the sensors:
// one read-modify-write per cycle, with in_i.ready low for the whole sweep.
// The window statistics are gathered during that same sweep.
// When a sample closes the window, a report sweep follows: one row per sensor
// on out_o in index order, last_of_run on the final row, each row read from
// the memory and cleared in place. Each row takes a read state and then a load
// state; a stalled row holds in the output register and the sweep waits.
// The last row may still wait on out_o while the next sample is accepted.
// cfg_i is always ready; index 0 sets window_samples, index 1 step_size,
// other indexes are ignored.
// Reset: counters read as zero through per-entry valid bits (no clearing
// pass), sample count zero, window_samples 1000, step_size 1.
`default_nettype none

module ir_ring_pulse_width_stats_unit #(
  parameter int SENSOR_COUNT = 15,
  parameter int WIDTH_BITS   = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  irpws_cfg_if.sink   cfg_i,
  irpws_in_if.sink    in_i,
  irpws_out_if.source out_o
);
  import irpws_pkg::*;

  localparam int IDX_W   = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int ACT_W   = $clog2(SENSOR_COUNT + 1);
  localparam int TOT_W   = WIDTH_BITS + ACT_W;
  localparam int PW_EXT  = (WIDTH_BITS > PULSE_WIDTH_W) ? WIDTH_BITS : PULSE_WIDTH_W;
  localparam int MW_EXT  = (WIDTH_BITS > MAX_WIDTH_W) ? WIDTH_BITS : MAX_WIDTH_W;
  localparam int TOT_EXT = (TOT_W > WIDTH_TOTAL_W) ? TOT_W : WIDTH_TOTAL_W;
  localparam int ACT_EXT = (ACT_W > ACTIVE_COUNT_W) ? ACT_W : ACTIVE_COUNT_W;
  localparam int IDX_EXT = (IDX_W > SENSOR_INDEX_W) ? IDX_W : SENSOR_INDEX_W;
  localparam logic [IDX_W-1:0]      LAST_IDX = IDX_W'(SENSOR_COUNT - 1);
  localparam logic [WIDTH_BITS-1:0] CNT_MAX  = {WIDTH_BITS{1'b1}};

  state_e state_q, state_d;

  logic [IDX_W-1:0]         idx_q;
  logic [SAMPLE_PINS_W-1:0] pins_q;
  logic [WINDOW_W-1:0]      window_q;
  logic [STEP_W-1:0]        step_q;
  logic [WINDOW_W-1:0]      samples_q;
  logic                     close_q;
  logic [ACT_W-1:0]         act_q;
  logic [TOT_W-1:0]         tot_q;
  logic [WIDTH_BITS-1:0]    max_q;
  logic [IDX_W-1:0]         maxs_q;

  logic [WIDTH_BITS-1:0]    mem [SENSOR_COUNT];
  logic [WIDTH_BITS-1:0]    rdata_q;
  logic                     rvalid_q;
  logic [SENSOR_COUNT-1:0]  valid_q;

  logic                      out_valid_q;
  logic [SENSOR_INDEX_W-1:0] out_index_q;
  logic [PULSE_WIDTH_W-1:0]  out_width_q;
  logic [ACTIVE_COUNT_W-1:0] out_active_q;
  logic [WIDTH_TOTAL_W-1:0]  out_total_q;
  logic [MAX_WIDTH_W-1:0]    out_max_q;
  logic [MAX_SENSOR_W-1:0]   out_maxs_q;
  logic                      out_last_q;

  logic                  in_ready;
  logic                  in_fire;
  logic                  cfg_fire;
  logic                  out_free;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [WIDTH_BITS-1:0] wr_data;
  logic                  out_load;
  logic                  idx_last;

  logic [WIDTH_BITS-1:0] cur_val;
  logic [WIDTH_BITS:0]   sum_val;
  logic [WIDTH_BITS-1:0] upd_val;
  logic [WINDOW_W-1:0]   limit;
  logic [WINDOW_W-1:0]   samples_inc;

  logic [PW_EXT-1:0]     pw_ext;
  logic [MW_EXT-1:0]     mw_ext;
  logic [TOT_EXT-1:0]    tot_ext;
  logic [ACT_EXT-1:0]    act_ext;
  logic [IDX_EXT-1:0]    idx_ext;
  logic [IDX_EXT-1:0]    maxs_ext;

  // handshakes
  assign in_i.ready  = in_ready;
  assign in_fire     = in_i.valid && in_ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;
  assign out_free    = !out_valid_q || out_o.ready;
  assign idx_last    = (idx_q == LAST_IDX);

  // counter update for the sensor under the sweep
  assign cur_val = rvalid_q ? rdata_q : '0;
  assign sum_val = {1'b0, cur_val} + (WIDTH_BITS + 1)'(step_q);
  assign upd_val = pins_q[0] ? cur_val : (sum_val[WIDTH_BITS] ? CNT_MAX : sum_val[WIDTH_BITS-1:0]);

  // window length and sample count
  assign limit       = (window_q == '0) ? WINDOW_W'(1) : window_q;
  assign samples_inc = samples_q + WINDOW_W'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (idx_last) state_d = close_q ? ST_EMIT_RD : ST_IDLE;
      end
      ST_EMIT_RD: begin
        if (out_free) state_d = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        state_d = idx_last ? ST_IDLE : ST_EMIT_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs: memory ports, input ready, row load
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = idx_q;
    wr_en    = 1'b0;
    wr_data  = '0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        rd_en    = in_fire;
        rd_addr  = '0;
      end
      ST_UPDATE: begin
        wr_en   = 1'b1;
        wr_data = upd_val;
        if (!idx_last) begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(idx_q + 1'b1);
        end
      end
      ST_EMIT_RD: begin
        rd_en = out_free;
      end
      ST_EMIT_LD: begin
        wr_en    = 1'b1;
        wr_data  = '0;
        out_load = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // state, sweep index and sample bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      samples_q <= '0;
      close_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        idx_q     <= '0;
        close_q   <= (samples_inc >= limit);
        samples_q <= (samples_inc >= limit) ? '0 : samples_inc;
      end else if (state_q == ST_UPDATE || state_q == ST_EMIT_LD) begin
        idx_q <= idx_last ? '0 : IDX_W'(idx_q + 1'b1);
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
      step_q   <= STEP_RESET;
    end else if (cfg_fire) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_WINDOW_SAMPLES: window_q <= cfg_i.data[WINDOW_W-1:0];
        REG_STEP_SIZE:      step_q   <= cfg_i.data[STEP_W-1:0];
        default:            ;
      endcase
    end
  end

  // sample latch, shifted one sensor per update cycle
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pins_q <= in_i.sample_pins;
    end else if (state_q == ST_UPDATE) begin
      pins_q <= {1'b0, pins_q[SAMPLE_PINS_W-1:1]};
    end
  end

  // window statistics gathered during the update sweep
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q  <= '0;
      tot_q  <= '0;
      max_q  <= '0;
      maxs_q <= '0;
    end else if (state_q == ST_UPDATE) begin
      if (upd_val != '0) begin
        act_q <= ACT_W'(act_q + 1'b1);
        tot_q <= tot_q + TOT_W'(upd_val);
      end
      if (upd_val > max_q) begin
        max_q  <= upd_val;
        maxs_q <= idx_q;
      end
    end
  end

  // counter memory with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[idx_q] <= wr_data;
    if (rd_en) begin
      rdata_q  <= mem[rd_addr];
      rvalid_q <= valid_q[rd_addr];
    end
  end

  // entry valid bits: an entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[idx_q] <= 1'b1;
    end
  end

  // output field saturation
  assign pw_ext   = PW_EXT'(cur_val);
  assign mw_ext   = MW_EXT'(max_q);
  assign tot_ext  = TOT_EXT'(tot_q);
  assign act_ext  = ACT_EXT'(act_q);
  assign idx_ext  = IDX_EXT'(idx_q);
  assign maxs_ext = IDX_EXT'(maxs_q);

  // report row register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_index_q  <= idx_ext[SENSOR_INDEX_W-1:0];
      out_width_q  <= (pw_ext > PW_EXT'({PULSE_WIDTH_W{1'b1}})) ? {PULSE_WIDTH_W{1'b1}}
                                                              : pw_ext[PULSE_WIDTH_W-1:0];
      out_active_q <= (act_ext > ACT_EXT'({ACTIVE_COUNT_W{1'b1}})) ? {ACTIVE_COUNT_W{1'b1}}
                                                                 : act_ext[ACTIVE_COUNT_W-1:0];
      out_total_q  <= (tot_ext > TOT_EXT'({WIDTH_TOTAL_W{1'b1}})) ? {WIDTH_TOTAL_W{1'b1}}
                                                                : tot_ext[WIDTH_TOTAL_W-1:0];
      out_max_q    <= (mw_ext > MW_EXT'({MAX_WIDTH_W{1'b1}})) ? {MAX_WIDTH_W{1'b1}}
                                                            : mw_ext[MAX_WIDTH_W-1:0];
      out_maxs_q   <= maxs_ext[MAX_SENSOR_W-1:0];
      out_last_q   <= idx_last;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.sensor_index = out_index_q;
  assign out_o.pulse_width  = out_width_q;
  assign out_o.active_count = out_active_q;
  assign out_o.width_total  = out_total_q;
  assign out_o.max_width    = out_max_q;
  assign out_o.max_sensor   = out_maxs_q;
  assign out_o.last_of_run  = out_last_q;

endmodule

`default_nettype wire

FILE: hdl/irpws_checker.sv
// port-level checker for the pulse width statistics unit, with its bind
`default_nettype none

module irpws_checker #(
  parameter int SENSOR_COUNT = 15
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [3:0]  sensor_index_i,
  input wire logic [23:0] pulse_width_i,
  input wire logic [23:0] max_width_i,
  input wire logic        last_of_run_i
);

  // a stalled row stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("report row dropped while stalled");

  // a stalled row keeps its contents
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(sensor_index_i) && $stable(pulse_width_i))
    else $error("report row changed while stalled");

  // no sensor width exceeds the window maximum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> max_width_i >= pulse_width_i)
    else $error("pulse width above window maximum");

  // the final row belongs to the last sensor of the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_of_run_i |-> sensor_index_i == 4'(SENSOR_COUNT - 1))
    else $error("last row flag on wrong sensor");

  // rows after the final one start again at sensor zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && last_of_run_i ##1 out_valid_i |-> sensor_index_i == 4'd0)
    else $error("report did not restart at sensor zero");

endmodule

bind ir_ring_pulse_width_stats_unit irpws_checker #(
  .SENSOR_COUNT (SENSOR_COUNT)
) u_irpws_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .sensor_index_i (out_o.sensor_index),
  .pulse_width_i  (out_o.pulse_width),
  .max_width_i    (out_o.max_width),
  .last_of_run_i  (out_o.last_of_run)
);

`default_nettype wire
